### rtl/core/hbp_pkg.sv
// Shared constants, action codes and the lookup-stage struct of the Huffman bit packer.
// Used by every module of the block except hbp_ram; depends on nothing.
package hbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int BYTE_BITS    = 8;

  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int ACT_W     = 2;
  localparam int PAD_W     = 4;
  localparam int TBL_DEPTH = 256;
  localparam int ENTRY_W   = CODE_W + LEN_W;

  // pending bits stay below one byte; a fold adds up to one full code
  localparam int ACC_W = BYTE_BITS - 1;
  localparam int V_W   = MAX_CODE_LEN + ACC_W;
  localparam int TOT_W = $clog2(V_W + 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } lk_item_t;

endpackage

### rtl/core/hbp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/hbp_table.sv
// Code table and lookup stage: writes loads into the table RAM, reads it for encodes.
// Depends on hbp_pkg and hbp_ram.
module hbp_table
  import hbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_length,
  output lk_item_t          lk,
  input  logic              lk_take
);

  logic               lk_valid_r, lk_valid_nxt;
  logic               lk_flush_r;
  logic               accept;
  logic               is_load, is_encode, is_flush;
  logic [LEN_W-1:0]   len_sat;
  logic [CODE_W-1:0]  code_masked;
  logic [ENTRY_W-1:0] rdata;

  assign in_ready  = !lk_valid_r || lk_take;
  assign accept    = in_valid && in_ready;
  assign is_load   = (in_action == ACT_LOAD);
  assign is_encode = (in_action == ACT_ENCODE);
  assign is_flush  = (in_action == ACT_FLUSH);

  // store codes already saturated and masked so the packer just shifts and ORs
  assign len_sat     = (in_code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                              : in_code_length;
  assign code_masked = in_code_value & ~({CODE_W{1'b1}} << len_sat);

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && is_load),
    .waddr (in_symbol),
    .wdata ({len_sat, code_masked}),
    .re    (accept && is_encode),
    .raddr (in_symbol),
    .rdata (rdata)
  );

  always_comb begin
    lk_valid_nxt = lk_valid_r;
    if (accept && (is_encode || is_flush)) begin
      lk_valid_nxt = 1'b1;
    end else if (lk_take) begin
      lk_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_valid_r <= 1'b0;
    end else begin
      lk_valid_r <= lk_valid_nxt;
    end
    if (accept) begin
      lk_flush_r <= is_flush;
    end
  end

  assign lk.valid = lk_valid_r;
  assign lk.flush = lk_flush_r;
  assign lk.code  = rdata[CODE_W-1:0];
  assign lk.len   = rdata[ENTRY_W-1:CODE_W];

endmodule

### rtl/core/hbp_packer.sv
// Bit accumulator and byte serializer with the output register.
// Depends on hbp_pkg.
module hbp_packer
  import hbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lk_item_t         lk,
  output logic             lk_take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_byte,
  output logic [PAD_W-1:0] out_pad,
  output logic             out_final,
  output logic             out_last
);

  // v_r holds the pending bits right aligned; tot_r counts them.
  // tot_r >= BYTE_BITS means whole bytes still wait to go out.
  logic [V_W-1:0]   v_r, v_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic             flush_r, flush_nxt;
  logic             ov_r, ov_nxt;
  logic [SYM_W-1:0] ob_r;
  logic [PAD_W-1:0] op_r;
  logic             of_r, ol_r;

  logic             slot_free, has_byte, emit, last_emit, settle;
  logic [TOT_W-1:0] tot_after;
  logic [V_W-1:0]   v_shift, acc_mask, v_fold;
  logic [SYM_W-1:0] enc_byte, fl_bits, fl_byte;
  logic [PAD_W-1:0] fl_pad;

  assign slot_free = !ov_r || out_ready;
  assign has_byte  = flush_r || (tot_r >= TOT_W'(BYTE_BITS));
  assign emit      = slot_free && has_byte;
  assign last_emit = flush_r || (tot_r < TOT_W'(2 * BYTE_BITS));
  assign settle    = !has_byte || (emit && last_emit);
  assign lk_take   = lk.valid && settle;

  always_comb begin
    tot_after = tot_r;
    if (emit) begin
      tot_after = flush_r ? '0 : tot_r - TOT_W'(BYTE_BITS);
    end
  end

  assign v_shift  = v_r >> (tot_r - TOT_W'(BYTE_BITS));
  assign enc_byte = v_shift[SYM_W-1:0];

  // flush: left-justify the pending bits into one byte, zeros on the right
  assign fl_bits = v_r[SYM_W-1:0] & ~({SYM_W{1'b1}} << tot_r[2:0]);
  assign fl_pad  = PAD_W'(BYTE_BITS) - {1'b0, tot_r[2:0]};
  assign fl_byte = fl_bits << fl_pad;

  assign acc_mask = ~({V_W{1'b1}} << tot_after);
  assign v_fold   = ((v_r & acc_mask) << lk.len) | V_W'(lk.code);

  always_comb begin
    v_nxt     = v_r;
    tot_nxt   = tot_after;
    flush_nxt = flush_r;
    if (emit && flush_r) begin
      flush_nxt = 1'b0;
    end
    if (lk_take) begin
      flush_nxt = lk.flush;
      if (!lk.flush) begin
        v_nxt   = v_fold;
        tot_nxt = tot_after + TOT_W'(lk.len);
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      tot_r   <= '0;
      flush_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      tot_r   <= tot_nxt;
      flush_r <= flush_nxt;
      ov_r    <= ov_nxt;
    end
    if (emit) begin
      ob_r <= flush_r ? fl_byte : enc_byte;
      op_r <= flush_r ? fl_pad : '0;
      of_r <= flush_r;
      ol_r <= last_emit;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_pad   = op_r;
  assign out_final = of_r;
  assign out_last  = ol_r;

endmodule

### rtl/core/huffman_table_bit_packer_unit.sv
// Top level of the Huffman table bit packer: table lookup stage feeding the byte packer.
// Depends on hbp_pkg, hbp_table and hbp_packer.
//
//   channel | direction | transfer moves
//   in_*    | slave     | one load, encode or flush item
//   out_*   | master    | one packed byte
//
// A load only writes the table. An encode or flush passes the lookup register to the packer,
// which takes it once its pending bytes have gone out; the output register drains one byte
// per cycle while out_tready is high. The table RAM read overlaps packing of the previous item.
// Reset clears the accumulator and the pipeline only; table entries are undefined until loaded.
// A stalled output holds its byte and backs up through the packer to in_tready.
module huffman_table_bit_packer_unit
  import hbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // symbol[7:0], code_value[39:8], code_length[45:40]
  input  logic [ACT_W-1:0]      in_tuser,  // action[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // out_byte[7:0], pad_bits[11:8]
  output logic                  out_tuser, // final_byte
  output logic                  out_tlast
);

  lk_item_t         lk;
  logic             lk_take;
  logic [SYM_W-1:0] byte_w;
  logic [PAD_W-1:0] pad_w;

  hbp_table u_table (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_action      (in_tuser),
    .in_symbol      (in_tdata[SYM_W-1:0]),
    .in_code_value  (in_tdata[SYM_W+CODE_W-1:SYM_W]),
    .in_code_length (in_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W]),
    .lk             (lk),
    .lk_take        (lk_take)
  );

  hbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .lk        (lk),
    .lk_take   (lk_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (byte_w),
    .out_pad   (pad_w),
    .out_final (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - PAD_W - SYM_W){1'b0}}, pad_w, byte_w};

endmodule

### rtl/core/hbp_checker.sv
// Port-level checks of the Huffman table bit packer, bound to the top level.
// Depends on hbp_pkg.
module hbp_checker
  import hbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // nothing comes out the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a flushed byte always closes its item
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("final byte without last");

  // flushed byte carries a pad of 1..8, ordinary bytes carry none
  a_final_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[11:8] != 4'd0) && (out_tdata[11:8] <= 4'd8))
    else $error("bad pad on final byte");

  a_plain_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[11:8] == 4'd0)
    else $error("pad on ordinary byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

endmodule

bind huffman_table_bit_packer_unit hbp_checker u_hbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### tb/huffman_table_bit_packer_unit_tb.sv
// Self-checking bench for huffman_table_bit_packer_unit: directed rows, then random traffic
// under changing backpressure, every packed byte compared with an in-bench bit packer or a typed row.
// Depends on hbp_pkg and the huffman_table_bit_packer_unit RTL.
module huffman_table_bit_packer_unit_tb;
  import hbp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 15;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0]       pbyte;
    logic [PAD_W-1:0] pad;
    logic             fin;
    logic             lst;
  } packed_byte_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] cv;
    logic [LEN_W-1:0]  cl;
    bit                has_exp;
    packed_byte_t      exp;
  } stim_row_t;

  localparam packed_byte_t NO_BYTE = '0;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  huffman_table_bit_packer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the code table and the bit accumulator
  logic [CODE_W-1:0] tbl_code [TBL_DEPTH];
  logic [LEN_W-1:0]  tbl_len  [TBL_DEPTH];
  logic [ACC_W-1:0]  acc_bits = '0;
  logic [2:0]        acc_cnt  = '0;

  packed_byte_t     packed_byte_q [$];
  bit               sym_loaded [TBL_DEPTH];
  logic [SYM_W-1:0] loaded_syms [$];
  stim_row_t        dir_rows [$];

  int err_cnt        = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  task automatic queue_byte(input packed_byte_t r);
    packed_byte_q.insert(packed_byte_q.size(), r);
  endtask

  task automatic add_row(input stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Updates the bench state for one accepted item; queues the bytes it yields when asked.
  task automatic pack_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] cv, input logic [LEN_W-1:0] cl,
                           input bit queue_bytes);
    logic [63:0]      code;
    logic [63:0]      v;
    logic [15:0]      fb;
    int               l;
    int               total;
    int               n;
    packed_byte_t     r;
    case (act)
      ACT_LOAD: begin
        tbl_code[sym] = cv;
        tbl_len[sym]  = (cl > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : cl;
        if (!sym_loaded[sym]) begin
          sym_loaded[sym] = 1'b1;
          loaded_syms.insert(loaded_syms.size(), sym);
        end
      end
      ACT_ENCODE: begin
        l = tbl_len[sym];
        if (l != 0) begin
          code = {32'b0, tbl_code[sym]};
          if (l < 32) code = code & ((64'd1 << l) - 64'd1);
          v     = ({57'b0, acc_bits} << l) | code;
          total = acc_cnt + l;
          n     = total / BYTE_BITS;
          for (int i = 0; i < n; i++) begin
            total   = total - BYTE_BITS;
            r.pbyte = 8'(v >> total);
            r.pad   = '0;
            r.fin   = 1'b0;
            r.lst   = (i == n - 1);
            if (queue_bytes) queue_byte(r);
          end
          acc_bits = ACC_W'(v & ((64'd1 << total) - 64'd1));
          acc_cnt  = 3'(total);
        end
      end
      ACT_FLUSH: begin
        r.pad   = PAD_W'(BYTE_BITS - acc_cnt);
        fb      = {9'b0, acc_bits} << r.pad;
        r.pbyte = fb[7:0];
        r.fin   = 1'b1;
        r.lst   = 1'b1;
        if (queue_bytes) queue_byte(r);
        acc_bits = '0;
        acc_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  // Offers one item and returns once its transfer has happened.
  task automatic offer_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] cv, input logic [LEN_W-1:0] cl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_DATA_W'({cl, cv, sym});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random item: mostly encodes of loaded symbols, some loads and flushes, a little noise.
  task automatic random_item();
    logic [ACT_W-1:0]  act;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] cv;
    logic [LEN_W-1:0]  cl;
    int                pick;
    int                lpick;
    pick = $urandom_range(99);
    sym  = SYM_W'($urandom_range(255));
    cv   = $urandom;
    cl   = LEN_W'($urandom_range(63));
    if (pick < 25 || loaded_syms.size() == 0) begin
      act   = ACT_LOAD;
      lpick = $urandom_range(9);
      if (lpick == 0)      cl = '0;
      else if (lpick == 1) cl = LEN_W'($urandom_range(63, 33));
      else                 cl = LEN_W'($urandom_range(32, 1));
    end else if (pick < 37) begin
      act = ACT_FLUSH;
    end else begin
      act = ACT_ENCODE;
      sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
    end
    offer_item(act, sym, cv, cl);
    pack_item(act, sym, cv, cl, 1'b1);
  endtask

  // Receiver: random stalls, long hold-off on request, and the result check.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (packed_byte_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected byte: data=%h final=%b last=%b", out_tdata, out_tuser,
                   out_tlast);
      end else begin
        if (out_tdata[7:0] !== packed_byte_q[0].pbyte ||
            out_tdata[11:8] !== packed_byte_q[0].pad ||
            out_tuser !== packed_byte_q[0].fin || out_tlast !== packed_byte_q[0].lst) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: byte %h/%h pad %0d/%0d final %b/%b last %b/%b (exp/act)",
                     packed_byte_q[0].pbyte, out_tdata[7:0], packed_byte_q[0].pad,
                     out_tdata[11:8], packed_byte_q[0].fin, out_tuser,
                     packed_byte_q[0].lst, out_tlast);
        end
        void'(packed_byte_q.pop_front());
      end
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen  <= hold_req_cnt;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // rows typed with an expectation are single flush bytes readable at a glance
    add_row('{ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd8, 1'b1, 1'b1}});
    add_row('{ACT_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'hFF, 32'h0000_0000, 6'd63, 1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'h41, 32'h0000_0005, 6'd3,  1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'h42, 32'h1234_5678, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'h10, 32'hFFFF_FFF3, 6'd2,  1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'h7F, 32'h0000_007F, 6'd7,  1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'h80, 32'h0000_00C3, 6'd8,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'hA0, 4'd5, 1'b1, 1'b1}});
    add_row('{ACT_ENCODE, 8'h42, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 4'd8, 1'b1, 1'b1}});
    add_row('{ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'hFE, 4'd1, 1'b1, 1'b1}});
    add_row('{ACT_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_LOAD,   8'h00, 32'h0000_0001, 6'd1,  1'b0, NO_BYTE});
    add_row('{ACT_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});
    add_row('{ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BYTE});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].act, dir_rows[i].sym, dir_rows[i].cv, dir_rows[i].cl);
      pack_item(dir_rows[i].act, dir_rows[i].sym, dir_rows[i].cv, dir_rows[i].cl,
                !dir_rows[i].has_exp);
      if (dir_rows[i].has_exp) queue_byte(dir_rows[i].exp);
    end

    // phases: free flow, sender idle, receiver stalls, both, then a long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 26 : 0;
      recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 26 : 0;
      if (ph == 4) hold_req_cnt++;
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end
    in_tvalid <= 1'b0;

    while (packed_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    err_cnt += packed_byte_q.size();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
